/* sv/arxp_pkg.sv */
// arxp_pkg: shared types, constants and helpers of the arx plant model step block
// no dependencies; imported by every module of the block
package arxp_pkg;

  localparam int DELAY_MAX    = 16;
  localparam int INPUT_LIMIT  = 20480;
  localparam int OUTPUT_LIMIT = 20480;

  localparam int SAMPLE_W   = 16;
  localparam int K_W        = $clog2(DELAY_MAX + 1);
  localparam int ADDR_W     = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 36;
  localparam int FRAC_SHIFT = 13;
  localparam int YS_W       = ACC_W - FRAC_SHIFT;
  localparam int ROUND_BIAS = 4096;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    REG_COEF_A_ONE   = 3'd0,
    REG_COEF_A_TWO   = 3'd1,
    REG_COEF_A_THREE = 3'd2,
    REG_COEF_B_ONE   = 3'd3,
    REG_COEF_B_TWO   = 3'd4,
    REG_COEF_B_THREE = 3'd5,
    REG_DELAY        = 3'd6,
    REG_LIMIT_EN     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MUL1,
    ENG_MUL2,
    ENG_FIN
  } eng_state_e;

  // delayed sample waiting for the mac engine
  typedef struct packed {
    logic    valid;
    sample_t sample;
  } stage_t;

  // delay register update towards the delay line
  typedef struct packed {
    logic           wr;
    logic [K_W-1:0] k_old;
    logic [K_W-1:0] k_new;
  } dly_cfg_t;

  function automatic logic [K_W-1:0] eff_delay(input logic [4:0] d);
    logic [K_W-1:0] k;
    if (int'(d) > DELAY_MAX) begin
      k = K_W'(DELAY_MAX);
    end else begin
      k = K_W'(d);
    end
    return k;
  endfunction

endpackage

/* sv/arxp_delay_line.sv */
// arxp_delay_line: transport delay held in a synchronous ring memory, with fill count
// input clamp and one-entry staging slot for the mac engine; uses arxp_pkg
module arxp_delay_line (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  arxp_pkg::sample_t  u_i,
  input  logic               limit_en_i,
  input  logic [arxp_pkg::K_W-1:0] k_i,
  input  arxp_pkg::dly_cfg_t dcfg_i,
  input  logic               take_i,
  output logic               ready_o,
  output arxp_pkg::stage_t   stg_o
);
  import arxp_pkg::*;

  localparam sample_t IN_HI = SAMPLE_W'(INPUT_LIMIT);
  localparam sample_t IN_LO = SAMPLE_W'(-INPUT_LIMIT);

  sample_t           mem [DELAY_MAX];
  sample_t           rd_q;
  logic [ADDR_W-1:0] wp_q, wp_d, ra;
  logic [K_W-1:0]    fill_q, fill_d, keep;
  logic [K_W:0]      ra_ext, wp_ext;
  logic              stg_valid_q, stg_valid_d;
  sample_t           stg_u_q;
  logic              stg_direct_q, stg_hit_q;
  sample_t           u_clamped;

  always_comb begin
    u_clamped = u_i;
    if (limit_en_i) begin
      if (u_i > IN_HI) begin
        u_clamped = IN_HI;
      end else if (u_i < IN_LO) begin
        u_clamped = IN_LO;
      end
    end
  end

  // oldest wanted sample was written k transactions ago
  always_comb begin
    wp_ext = (K_W+1)'(wp_q);
    if (wp_ext >= (K_W+1)'(k_i)) begin
      ra_ext = wp_ext - (K_W+1)'(k_i);
    end else begin
      ra_ext = wp_ext + (K_W+1)'(DELAY_MAX) - (K_W+1)'(k_i);
    end
    ra = ra_ext[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q     <= mem[ra];
      mem[wp_q] <= u_clamped;
    end
  end

  always_comb begin
    keep   = (dcfg_i.k_old < dcfg_i.k_new) ? dcfg_i.k_old : dcfg_i.k_new;
    wp_d   = wp_q;
    fill_d = fill_q;
    if (acc_i) begin
      wp_d = (int'(wp_q) == DELAY_MAX - 1) ? '0 : wp_q + ADDR_W'(1);
      if (int'(fill_q) != DELAY_MAX) begin
        fill_d = fill_q + K_W'(1);
      end
    end else if (dcfg_i.wr && (fill_q > keep)) begin
      fill_d = keep;
    end
  end

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (take_i) begin
      stg_valid_d = 1'b0;
    end
    if (acc_i) begin
      stg_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      stg_u_q      <= u_clamped;
      stg_direct_q <= (k_i == '0);
      stg_hit_q    <= (k_i <= fill_q);
    end
  end

  assign ready_o   = !stg_valid_q || take_i;
  assign stg_o.valid  = stg_valid_q;
  assign stg_o.sample = stg_direct_q ? stg_u_q : (stg_hit_q ? rd_q : '0);

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= DELAY_MAX) else $error("fill count beyond delay depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && stg_valid_q) |-> take_i) else $error("staged sample overwritten");
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wp_q) < DELAY_MAX) else $error("write pointer out of range");

endmodule

/* sv/arxp_mac.sv */
// arxp_mac: difference equation engine, two shared multipliers over three steps,
// accumulator, rounding, clamp, histories and output register; uses arxp_pkg
module arxp_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  arxp_pkg::stage_t        stg_i,
  input  arxp_pkg::sample_t [2:0] coef_a_i,
  input  arxp_pkg::sample_t [2:0] coef_b_i,
  input  logic                    limit_en_i,
  input  logic                    out_ready_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  output arxp_pkg::sample_t       out_data_o
);
  import arxp_pkg::*;

  eng_state_e state_q, state_d;

  sample_t uh_q [3];
  sample_t yh_q [3];

  logic signed [SAMPLE_W-1:0] mb_c, mb_x, ma_c, ma_x;
  logic signed [PROD_W-1:0]   pb_q, pa_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d, sum_fin, sum_sh;
  logic signed [YS_W-1:0]     y_wide, y_hi, y_lo;
  sample_t                    y_fin;
  logic                       prod_en, out_free, fin_go;
  logic                       out_valid_q;
  sample_t                    out_data_q;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ENG_IDLE: begin
        if (stg_i.valid) begin
          state_d = ENG_MUL1;
        end
      end
      ENG_MUL1: state_d = ENG_MUL2;
      ENG_MUL2: state_d = ENG_FIN;
      ENG_FIN: begin
        if (out_free) begin
          state_d = ENG_IDLE;
        end
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  always_comb begin
    take_o  = 1'b0;
    prod_en = 1'b0;
    fin_go  = 1'b0;
    mb_c    = coef_b_i[0];
    mb_x    = stg_i.sample;
    ma_c    = coef_a_i[0];
    ma_x    = yh_q[0];
    case (state_q)
      ENG_IDLE: begin
        take_o  = stg_i.valid;
        prod_en = stg_i.valid;
      end
      ENG_MUL1: begin
        prod_en = 1'b1;
        mb_c    = coef_b_i[1];
        mb_x    = uh_q[1];
        ma_c    = coef_a_i[1];
        ma_x    = yh_q[1];
      end
      ENG_MUL2: begin
        prod_en = 1'b1;
        mb_c    = coef_b_i[2];
        mb_x    = uh_q[2];
        ma_c    = coef_a_i[2];
        ma_x    = yh_q[2];
      end
      ENG_FIN: fin_go = out_free;
      default: ;
    endcase
  end

  // accumulator starts at the rounding bias so the final shift rounds half up
  always_comb begin
    sum_fin = acc_q + ACC_W'(pb_q) - ACC_W'(pa_q);
    acc_d   = acc_q;
    if (take_o) begin
      acc_d = ACC_W'(ROUND_BIAS);
    end else if ((state_q == ENG_MUL1) || (state_q == ENG_MUL2)) begin
      acc_d = sum_fin;
    end
  end

  always_comb begin
    sum_sh = sum_fin >>> FRAC_SHIFT;
    y_wide = sum_sh[YS_W-1:0];
    y_hi   = limit_en_i ? YS_W'(OUTPUT_LIMIT) : YS_W'(SAMPLE_MAX);
    y_lo   = limit_en_i ? YS_W'(-OUTPUT_LIMIT) : YS_W'(SAMPLE_MIN);
    if (y_wide > y_hi) begin
      y_fin = y_hi[SAMPLE_W-1:0];
    end else if (y_wide < y_lo) begin
      y_fin = y_lo[SAMPLE_W-1:0];
    end else begin
      y_fin = y_wide[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      pb_q <= mb_c * mb_x;
      pa_q <= ma_c * ma_x;
    end
    acc_q <= acc_d;
    if (fin_go) begin
      out_data_q <= y_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        uh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
        yh_q[0]     <= y_fin;
        yh_q[1]     <= yh_q[0];
        yh_q[2]     <= yh_q[1];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take_o) begin
        uh_q[0] <= stg_i.sample;
        uh_q[1] <= uh_q[0];
        uh_q[2] <= uh_q[1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_take_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> (state_q == ENG_MUL1)) else $error("take not followed by first step");
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ENG_FIN) && !out_free) |=> (state_q == ENG_FIN))
    else $error("result dropped under back-pressure");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ENG_FIN))
    else $error("result appeared outside final step");

endmodule

/* sv/arx_plant_model_step.sv */
// arx_plant_model_step: third-order arx plant model, top level with apb register file
// instantiates arxp_delay_line and arxp_mac; uses arxp_pkg
// path: staging slot, then mac steps idle, mul1, mul2 and fin, then the output register
// the mac steps take one transaction at a time, set by the output feedback loop
// reset: coefficients zero, delay zero, limits on, all histories read as zero (fill count)
// a result waiting for m_axis_tready does not stop the next input transaction
module arx_plant_model_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // tdata: u_sample [15:0]
  input  logic [15:0]               s_axis_tdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: y_sample [15:0]
  output logic [15:0]               m_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [arxp_pkg::APB_AW-1:0] paddr,
  input  logic [arxp_pkg::APB_DW-1:0] pwdata,
  output logic [arxp_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import arxp_pkg::*;

  sample_t [2:0] coef_a_q, coef_b_q;
  logic [4:0]    delay_q;
  logic          limit_en_q;
  logic          cfg_wr, in_acc, take, out_valid;
  reg_idx_e      idx;
  dly_cfg_t      dcfg;
  stage_t        stg;
  sample_t       out_data;
  logic          dl_ready;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= '0;
      coef_b_q   <= '0;
      delay_q    <= '0;
      limit_en_q <= 1'b1;
    end else if (cfg_wr) begin
      case (idx)
        REG_COEF_A_ONE:   coef_a_q[0] <= pwdata[15:0];
        REG_COEF_A_TWO:   coef_a_q[1] <= pwdata[15:0];
        REG_COEF_A_THREE: coef_a_q[2] <= pwdata[15:0];
        REG_COEF_B_ONE:   coef_b_q[0] <= pwdata[15:0];
        REG_COEF_B_TWO:   coef_b_q[1] <= pwdata[15:0];
        REG_COEF_B_THREE: coef_b_q[2] <= pwdata[15:0];
        REG_DELAY:        delay_q     <= pwdata[4:0];
        REG_LIMIT_EN:     limit_en_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF_A_ONE:   prdata = APB_DW'(coef_a_q[0]);
      REG_COEF_A_TWO:   prdata = APB_DW'(coef_a_q[1]);
      REG_COEF_A_THREE: prdata = APB_DW'(coef_a_q[2]);
      REG_COEF_B_ONE:   prdata = APB_DW'(coef_b_q[0]);
      REG_COEF_B_TWO:   prdata = APB_DW'(coef_b_q[1]);
      REG_COEF_B_THREE: prdata = APB_DW'(coef_b_q[2]);
      REG_DELAY:        prdata = APB_DW'(delay_q);
      REG_LIMIT_EN:     prdata = APB_DW'(limit_en_q);
      default:          prdata = '0;
    endcase
  end

  assign dcfg.wr    = cfg_wr && (idx == REG_DELAY);
  assign dcfg.k_old = eff_delay(delay_q);
  assign dcfg.k_new = eff_delay(pwdata[4:0]);

  assign s_axis_tready = dl_ready;
  assign in_acc        = s_axis_tvalid && dl_ready;

  arxp_delay_line u_dly (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .u_i        (s_axis_tdata),
    .limit_en_i (limit_en_q),
    .k_i        (dcfg.k_old),
    .dcfg_i     (dcfg),
    .take_i     (take),
    .ready_o    (dl_ready),
    .stg_o      (stg)
  );

  arxp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_i       (stg),
    .coef_a_i    (coef_a_q),
    .coef_b_i    (coef_b_q),
    .limit_en_i  (limit_en_q),
    .out_ready_i (m_axis_tready),
    .take_o      (take),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
